FILE: rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared constants and types for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;   // power of two
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;

  localparam logic [7:0] BLANK_ATTR = 8'h07;

  // control bytes
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // op codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register indexes
  localparam logic REG_TEXT_ATTR = 1'b0;

  typedef struct packed {
    logic              chr_we;
    logic              att_we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        chr;
    logic [7:0]        att;
  } mem_wr_t;

  typedef struct packed {
    logic chr_we;
    logic att_we;
    logic scroll;
  } put_eff_t;

endpackage

FILE: rtl/text_console_char_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// 80x25 text console: put bytes at a cursor, read back cells, scroll.
// ----------------------------------------------------------------------------
//  port group | direction | words
//  in_*       | sink      | put byte (tuser=0) or cell read (tuser=1)
//  out_*      | source    | one result word per input word
//  cfg_*      | APB slave | text_attribute at byte address 0
//
// A put that scrolls holds input off while all COLUMNS cells of the new bottom
// row are filled (rows are rotated through a base offset, so no rows are
// copied). A read passes through the memory read port register and then
// the output register.
// After reset the cell memory is cleared, one cell a cycle, before the first
// input word is taken.
// A stalled output holds one result; input is taken again as it drains.
module text_console_char_writer_core
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input: tdata = char_code[7:0], cell_index[18:8]; tuser = op
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic        in_tuser,
  // output: tdata = cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
  //         cell_attr[27:20], scrolled[28]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [COL_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [ADDR_W-1:0] base_off_r, base_off_nxt;
  logic [7:0]        text_attr_r;
  logic              rd_oob_r;

  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  logic              in_op;
  logic [7:0]        in_char;
  logic [10:0]       in_index;
  logic              in_fire, put_fire, read_fire;
  logic              out_free;

  put_eff_t          eff;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic [ADDR_W:0]   put_sum, rd_sum, base_sum;
  logic [ADDR_W-1:0] put_addr, rd_addr;
  logic              rd_oob;
  mem_wr_t           wr;
  logic [7:0]        rd_chr, rd_att;
  logic              cfg_wr;

  assign in_op    = in_tuser;
  assign in_char  = in_tdata[7:0];
  assign in_index = in_tdata[18:8];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign put_fire  = in_fire && (in_op == OP_PUT);
  assign read_fire = in_fire && (in_op == OP_READ);

  tccw_cursor u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .put_fire  (put_fire),
    .char_code (in_char),
    .eff       (eff),
    .col_r     (col_r),
    .row_r     (row_r),
    .col_nxt   (col_nxt),
    .row_nxt   (row_nxt)
  );

  // logical cell -> physical cell through the rotating row base
  assign put_sum  = (ADDR_W+1)'(row_r) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(col_r)
                  + {1'b0, base_off_r};
  assign put_addr = (put_sum >= (ADDR_W+1)'(CELL_COUNT))
                  ? ADDR_W'(put_sum - (ADDR_W+1)'(CELL_COUNT)) : put_sum[ADDR_W-1:0];
  assign rd_oob   = in_index >= 11'(CELL_COUNT);
  assign rd_sum   = (ADDR_W+1)'(in_index) + {1'b0, base_off_r};
  assign rd_addr  = (rd_sum >= (ADDR_W+1)'(CELL_COUNT))
                  ? ADDR_W'(rd_sum - (ADDR_W+1)'(CELL_COUNT)) : rd_sum[ADDR_W-1:0];
  assign base_sum = {1'b0, base_off_r} + (ADDR_W+1)'(COLUMNS);

  always_comb begin
    wr = '0;
    case (state_r)
      ST_CLEAR: begin
        wr.chr_we = 1'b1;
        wr.att_we = 1'b1;
        wr.addr   = sweep_addr_r;
      end
      ST_FILL: begin
        wr.chr_we = 1'b1;
        wr.att_we = 1'b1;
        wr.addr   = sweep_addr_r;
        wr.att    = BLANK_ATTR;
      end
      ST_IDLE: begin
        wr.chr_we = put_fire && eff.chr_we;
        wr.att_we = put_fire && eff.att_we;
        wr.addr   = put_addr;
        wr.chr    = in_char;
        // backspace clears the attribute only
        wr.att    = eff.chr_we ? text_attr_r : 8'h00;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  tccw_screen_mem u_mem (
    .clk      (clk),
    .wr       (wr),
    .rd_en    (read_fire),
    .rd_addr  (rd_addr),
    .rd_chr_r (rd_chr),
    .rd_att_r (rd_att)
  );

  always_comb begin
    state_nxt      = state_r;
    sweep_addr_nxt = sweep_addr_r;
    fill_cnt_nxt   = fill_cnt_r;
    base_off_nxt   = base_off_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (put_fire) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b0, eff.scroll, 8'h00, 8'h00, row_nxt, col_nxt};
          if (eff.scroll) begin
            // old top row becomes the new bottom row
            sweep_addr_nxt = base_off_r;
            fill_cnt_nxt   = '0;
            base_off_nxt   = (base_sum >= (ADDR_W+1)'(CELL_COUNT))
                           ? ADDR_W'(base_sum - (ADDR_W+1)'(CELL_COUNT))
                           : base_sum[ADDR_W-1:0];
            state_nxt      = ST_FILL;
          end
        end else if (read_fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {3'b0, 1'b0,
                         rd_oob_r ? 8'h00 : rd_att,
                         rd_oob_r ? 8'h00 : rd_chr,
                         row_r, col_r};
        state_nxt     = ST_IDLE;
      end
      ST_FILL: begin
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        fill_cnt_nxt   = fill_cnt_r + 1'b1;
        if (fill_cnt_r == COL_W'(COLUMNS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      sweep_addr_r <= '0;
      fill_cnt_r   <= '0;
      base_off_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      base_off_r   <= base_off_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (read_fire) begin
      rd_oob_r <= rd_oob;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= BLANK_ATTR;
    end else if (cfg_wr && (cfg_paddr[2] == REG_TEXT_ATTR)) begin
      text_attr_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TEXT_ATTR) ? {24'h0, text_attr_r} : 32'h0;

endmodule

FILE: rtl/tccw_screen_mem.sv
// ----------------------------------------------------------------------------
// tccw_screen_mem
// Screen cell store: separate character and attribute arrays, one write
// port with per-byte enables, one registered read port.
// ----------------------------------------------------------------------------
module tccw_screen_mem
  import tccw_pkg::*;
(
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_chr_r,
  output logic [7:0]        rd_att_r
);

  logic [7:0] chr_mem [CELL_COUNT];
  logic [7:0] att_mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.chr_we) begin
      chr_mem[wr.addr] <= wr.chr;
    end
    if (wr.att_we) begin
      att_mem[wr.addr] <= wr.att;
    end
    if (rd_en) begin
      rd_chr_r <= chr_mem[rd_addr];
      rd_att_r <= att_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/tccw_cursor.sv
// ----------------------------------------------------------------------------
// tccw_cursor
// Cursor registers and put-byte decode: next cursor position, which cell
// bytes get written, and whether the put scrolls the screen.
// ----------------------------------------------------------------------------
module tccw_cursor
  import tccw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             put_fire,
  input  logic [7:0]       char_code,
  output put_eff_t         eff,
  output logic [COL_W-1:0] col_r,
  output logic [ROW_W-1:0] row_r,
  output logic [COL_W-1:0] col_nxt,
  output logic [ROW_W-1:0] row_nxt
);

  logic [COL_W-1:0] col_adv;
  logic [ROW_W-1:0] row_adv;
  logic             row_inc;
  logic [7:0]       tab_pos;

  // next tab stop, power-of-two tab width
  assign tab_pos = {1'b0, col_r} + 8'(TAB_WIDTH) - ({1'b0, col_r} & 8'(TAB_WIDTH - 1));

  always_comb begin
    col_adv    = col_r;
    row_inc    = 1'b0;
    eff.chr_we = 1'b0;
    eff.att_we = 1'b0;
    case (char_code)
      CH_LF: begin
        col_adv = '0;
        row_inc = 1'b1;
      end
      CH_BS: begin
        if (col_r != '0) begin
          eff.att_we = 1'b1;
          col_adv    = col_r - 1'b1;
        end
      end
      CH_TAB: begin
        if (tab_pos >= 8'(COLUMNS)) begin
          col_adv = '0;
          row_inc = 1'b1;
        end else begin
          col_adv = tab_pos[COL_W-1:0];
        end
      end
      CH_CR: begin
        col_adv = '0;
      end
      default: begin
        eff.chr_we = 1'b1;
        eff.att_we = 1'b1;
        if (col_r == COL_W'(COLUMNS - 1)) begin
          col_adv = '0;
          row_inc = 1'b1;
        end else begin
          col_adv = col_r + 1'b1;
        end
      end
    endcase
    eff.scroll = row_inc && (row_r == ROW_W'(ROWS - 1));
    row_adv    = (row_inc && !eff.scroll) ? row_r + 1'b1 : row_r;
  end

  assign col_nxt = put_fire ? col_adv : col_r;
  assign row_nxt = put_fire ? row_adv : row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console character writer. Puts and cell
// reads go in over the input stream with random gaps, the result stream is
// stalled at random, and each result word is compared with a software copy
// of the screen, cursor and attribute register kept by a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tccw_pkg::*;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          ITEMS_PER_PHASE = 300;
  localparam int          PHASES = 5;
  localparam logic [2:0]  ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  // result word, lowest field last
  typedef struct packed {
    logic [2:0] pad;
    logic       scrolled;
    logic [7:0] attr;
    logic [7:0] chr;
    logic [4:0] row;
    logic [6:0] col;
  } result_word_t;

  class console_scoreboard;
    logic [7:0]   glyph [CELL_COUNT];
    logic [7:0]   shade [CELL_COUNT];
    int unsigned  col;
    int unsigned  row;
    logic [7:0]   text_attr;
    result_word_t expected_results [$];
    int           mismatches;

    function new();
      for (int i = 0; i < CELL_COUNT; i++) begin
        glyph[i] = '0;
        shade[i] = '0;
      end
      col = 0;
      row = 0;
      text_attr = 8'h07;
      mismatches = 0;
    endfunction

    function void set_attribute(logic [7:0] value);
      text_attr = value;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void scroll_up();
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
        glyph[i] = glyph[i + COLUMNS];
        shade[i] = shade[i + COLUMNS];
      end
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
        glyph[i] = '0;
        shade[i] = BLANK_ATTR;
      end
    endfunction

    function bit put_byte(logic [7:0] ch);
      int unsigned here;
      here = row * COLUMNS + col;
      if (here >= CELL_COUNT) here = CELL_COUNT - 1;
      case (ch)
        CH_LF: begin
          col = 0;
          row++;
        end
        CH_BS: begin
          if (col != 0) begin
            shade[here] = '0;
            col--;
          end
        end
        CH_TAB: begin
          col = col + TAB_WIDTH - (col % TAB_WIDTH);
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
        end
        CH_CR: col = 0;
        default: begin
          glyph[here] = ch;
          shade[here] = text_attr;
          col++;
          if (col > COLUMNS - 1) begin
            col = 0;
            row++;
          end
        end
      endcase
      if (row > ROWS - 1) begin
        scroll_up();
        row = ROWS - 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // called once per accepted input word
    function void note_word(logic op, logic [7:0] ch, logic [10:0] idx);
      result_word_t r;
      r = '0;
      if (op == OP_PUT) begin
        r.scrolled = put_byte(ch);
      end else if (idx < CELL_COUNT) begin
        r.chr  = glyph[idx];
        r.attr = shade[idx];
      end
      r.col = col[6:0];
      r.row = row[4:0];
      expected_results.push_back(r);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [31:0] word);
      result_word_t got;
      result_word_t want;
      got = word;
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", word);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("cursor_col", want.col, got.col);
      compare_field("cursor_row", want.row, got.row);
      compare_field("cell_char", want.chr, got.chr);
      compare_field("cell_attr", want.attr, got.attr);
      compare_field("scrolled", want.scrolled, got.scrolled);
      compare_field("padding", want.pad, got.pad);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  console_scoreboard board = new();
  int  cfg_errors = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  sender_steady = 1'b0;
  bit  sink_steady = 1'b0;

  text_console_char_writer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // char_code[7:0], cell_index[18:8]
    .in_tuser   (in_tuser),     // op
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // col, row, char, attr, scrolled
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, mostly short
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 5) == 0) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // valid stays high after a handshake; the next call lowers it only for a gap
  task automatic send_word(input logic op, input logic [7:0] ch, input logic [10:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, idx, ch};
    do @(posedge clk); while (!in_tready);
    board.note_word(op, ch, idx);
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_word(OP_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [10:0] idx);
    send_word(OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // a scroll may still be filling the bottom row after its result is out
  task automatic wait_idle();
    wait_results();
    repeat (COLUMNS + 8) @(posedge clk);
  endtask

  task automatic write_text_attr(input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ATTR_ADDR;
    cfg_pwdata  <= {24'($urandom()), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_attribute(value);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== value) begin
      $error("text_attribute: expected %0d, got %0d", value, cfg_prdata[7:0]);
      cfg_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CH_BS;
    if (r < 18) return CH_TAB;
    if (r < 26) return CH_LF;
    if (r < 30) return CH_CR;
    if (r < 48) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_word();
    int r;
    logic [10:0] idx;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      // nearly half on the cursor's row, where fresh text sits
      if (r < 12) idx = 11'(board.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
      else if (r < 21) idx = 11'($urandom_range(0, CELL_COUNT - 1));
      else idx = 11'($urandom_range(0, 2047));
      read_cell(idx);
    end else begin
      put_char(pick_char());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cleared cell, byte extremes, control bytes, reads off screen
    read_cell(11'd0);
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    read_cell(11'd0);
    read_cell(11'd2);
    put_char(CH_BS);
    read_cell(11'd3);
    put_char(8'h7E);
    put_char(CH_CR);
    put_char(CH_BS);
    put_char(CH_TAB);
    put_char(CH_TAB);
    put_char(CH_LF);
    read_cell(11'd1999);
    read_cell(11'd2000);
    read_cell(11'd2047);
    read_cell(11'd1024);
    put_char(8'h80);
    read_cell(11'd80);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: write_text_attr(8'h00);
          2: write_text_attr(8'hFF);
          default: write_text_attr(8'($urandom_range(0, 255)));
        endcase
      end
      sender_steady = (phase == 2);
      sink_steady   = (phase == 2);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 1 && i == ITEMS_PER_PHASE / 2) wait_results();
        random_word();
      end
    end

    wait_results();
    repeat (COLUMNS + 8) @(posedge clk);
    if (board.mismatches == 0 && cfg_errors == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
